// ===== rtl/tgbu_pkg.sv =====
// Shared types, widths and codes for the thermal grid bilinear upscaler.
package tgbu_pkg;

   localparam int GRID_ROWS_DEF = 8;
   localparam int GRID_COLS_DEF = 8;

   localparam int CELL_W   = 3;
   localparam int SAMPLE_W = 12;
   localparam int SUB_W    = 10;
   localparam int DISP_W   = 11;
   localparam int COORD_W  = 12;
   localparam int GRAY_W   = 8;
   localparam int WPROD_W  = 16;
   localparam int SUM_W    = 29;
   localparam int NUM_W    = 18;

   localparam int DIV_STAGES  = 4;
   localparam int DIV_BPS     = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 16;
   localparam int RECIP_SHIFT = 22;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_HEIGHT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_WIDTH  = 1'b1;

   localparam logic [DISP_W-1:0] DISPLAY_HEIGHT_RST = 11'd240;
   localparam logic [DISP_W-1:0] DISPLAY_WIDTH_RST  = 11'd320;

   typedef struct packed {
      logic                       operation;
      logic                       grid_select;
      logic [CELL_W-1:0]          cell_row;
      logic [CELL_W-1:0]          cell_col;
      logic signed [SAMPLE_W-1:0] sample;
      logic [SUB_W-1:0]           sub_y;
      logic [SUB_W-1:0]           sub_x;
      logic [SUB_W-1:0]           base_y;
      logic [SUB_W-1:0]           base_x;
   } req_type;

   typedef struct packed {
      logic [GRAY_W-1:0]  gray_value;
      logic [COORD_W-1:0] screen_y;
      logic [COORD_W-1:0] screen_x;
      logic               in_range;
   } rsp_type;

   typedef struct packed {
      logic                is_query;
      logic                write_ok;
      logic                in_grid;
      logic [CELL_W-1:0]   cell_row;
      logic [CELL_W-1:0]   cell_col;
      logic [SAMPLE_W-1:0] sample;
      logic [SUB_W-1:0]    sub_y;
      logic [SUB_W-1:0]    sub_x;
      logic [SUB_W-1:0]    base_y;
      logic [SUB_W-1:0]    base_x;
   } cmd_type;

endpackage

// ===== rtl/tgbu_ram.sv =====
// Generic single write port RAM with one registered read port.
module tgbu_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tgbu_front.sv =====
// Front end: classifies requests, forms grid addresses and queues commands.
module tgbu_front #(
   parameter int GRID_ROWS = tgbu_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = tgbu_pkg::GRID_COLS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tgbu_pkg::req_type         req_data,
   output logic                      full,
   input  logic                      busy,
   output logic                      q_valid,
   input  logic                      q_pop,
   output tgbu_pkg::cmd_type         q_cmd,
   output logic [$clog2(2*GRID_ROWS*GRID_COLS)-1:0]      q_wr_addr,
   output logic [3:0][$clog2(2*GRID_ROWS*GRID_COLS)-1:0] q_rd_addr
);

   localparam int CELLS = GRID_ROWS * GRID_COLS;
   localparam int AW    = $clog2(2 * CELLS);
   localparam int QD    = tgbu_pkg::QUEUE_DEPTH;
   localparam int QPW   = $clog2(QD);
   localparam int QCW   = $clog2(QD + 1);

   function automatic int unsigned sat_idx(input int unsigned i, input int unsigned n);
      return (i < n) ? i : (n - 1);
   endfunction

   tgbu_pkg::cmd_type      cmd_new;
   logic [AW-1:0]          wr_new;
   logic [3:0][AW-1:0]     rd_new;

   tgbu_pkg::cmd_type      cmd_ff [QD];
   logic [AW-1:0]          wr_ff  [QD];
   logic [3:0][AW-1:0]     rd_ff  [QD];
   logic [QPW-1:0]         wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCW-1:0]         count_ff, count_in;
   logic                   accept;

   always_comb begin
      int unsigned row, col, r0, r1, c0, c1, base;
      row  = 32'(req_data.cell_row);
      col  = 32'(req_data.cell_col);
      r0   = sat_idx(row, GRID_ROWS);
      r1   = sat_idx(row + 1, GRID_ROWS);
      c0   = sat_idx(col, GRID_COLS);
      c1   = sat_idx(col + 1, GRID_COLS);
      base = req_data.grid_select ? CELLS : 0;
      rd_new[0] = AW'(base + r0 * GRID_COLS + c0);
      rd_new[1] = AW'(base + r0 * GRID_COLS + c1);
      rd_new[2] = AW'(base + r1 * GRID_COLS + c0);
      rd_new[3] = AW'(base + r1 * GRID_COLS + c1);
      wr_new    = AW'(base + row * GRID_COLS + col);
      cmd_new.is_query = (req_data.operation == tgbu_pkg::OP_QUERY);
      cmd_new.write_ok = (row < GRID_ROWS) && (col < GRID_COLS);
      cmd_new.in_grid  = (row + 1 < GRID_ROWS) && (col + 1 < GRID_COLS);
      cmd_new.cell_row = req_data.cell_row;
      cmd_new.cell_col = req_data.cell_col;
      cmd_new.sample   = req_data.sample;
      cmd_new.sub_y    = req_data.sub_y;
      cmd_new.sub_x    = req_data.sub_x;
      cmd_new.base_y   = req_data.base_y;
      cmd_new.base_x   = req_data.base_x;
   end

   assign full    = (count_ff == QCW'(QD)) || busy;
   assign accept  = push && !full;
   assign q_valid = (count_ff != '0);

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (accept) begin
         wptr_in = (wptr_ff == QPW'(QD - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (q_pop) begin
         rptr_in = (rptr_ff == QPW'(QD - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (accept && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff[wptr_ff] <= cmd_new;
         wr_ff[wptr_ff]  <= wr_new;
         rd_ff[wptr_ff]  <= rd_new;
      end
   end

   assign q_cmd     = cmd_ff[rptr_ff];
   assign q_wr_addr = wr_ff[rptr_ff];
   assign q_rd_addr = rd_ff[rptr_ff];

endmodule

// ===== rtl/tgbu_wdiv.sv =====
// Pipelined restoring divider for the 8-bit interpolation weight.
module tgbu_wdiv (
   input  logic                          clock,
   input  logic [tgbu_pkg::NUM_W-1:0]    numer,
   input  logic [tgbu_pkg::DISP_W-1:0]   divisor,
   output logic [tgbu_pkg::GRAY_W-1:0]   quot
);

   localparam int N  = tgbu_pkg::DIV_STAGES;
   localparam int DW = tgbu_pkg::DISP_W;
   localparam int QW = tgbu_pkg::GRAY_W;

   logic [DW-1:0] rem_s [0:N];
   logic [QW-1:0] low_s [0:N];
   logic [QW-1:0] q_s   [0:N];
   logic [DW-1:0] d_s   [0:N];

   // upper numerator bits are already below the divisor when the weight is in range
   assign rem_s[0] = DW'(numer[tgbu_pkg::NUM_W-1:QW]);
   assign low_s[0] = numer[QW-1:0];
   assign q_s[0]   = '0;
   assign d_s[0]   = divisor;

   for (genvar k = 1; k <= N; k++) begin : g_stage
      logic [DW-1:0] rem_ff, rem_in;
      logic [QW-1:0] low_ff, low_in, q_ff, q_in;
      logic [DW-1:0] d_ff;

      always_comb begin
         logic [DW:0] sh;
         rem_in = rem_s[k-1];
         low_in = low_s[k-1];
         q_in   = q_s[k-1];
         for (int b = 0; b < tgbu_pkg::DIV_BPS; b++) begin
            sh     = {rem_in, low_in[QW-1]};
            low_in = low_in << 1;
            if (sh >= {1'b0, d_s[k-1]}) begin
               sh   = sh - {1'b0, d_s[k-1]};
               q_in = {q_in[QW-2:0], 1'b1};
            end else begin
               q_in = {q_in[QW-2:0], 1'b0};
            end
            rem_in = sh[DW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         q_ff   <= q_in;
         d_ff   <= d_s[k-1];
      end

      assign rem_s[k] = rem_ff;
      assign low_s[k] = low_ff;
      assign q_s[k]   = q_ff;
      assign d_s[k]   = d_ff;
   end

   assign quot = q_s[N];

endmodule

// ===== rtl/tgbu_back.sv =====
// Back end: grid stores, interpolation pipeline and result queue.
module tgbu_back #(
   parameter int GRID_ROWS = tgbu_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = tgbu_pkg::GRID_COLS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [tgbu_pkg::DISP_W-1:0]                   block_h,
   input  logic [tgbu_pkg::DISP_W-1:0]                   block_w,
   input  logic                                          q_valid,
   input  tgbu_pkg::cmd_type                             q_cmd,
   input  logic [$clog2(2*GRID_ROWS*GRID_COLS)-1:0]      q_wr_addr,
   input  logic [3:0][$clog2(2*GRID_ROWS*GRID_COLS)-1:0] q_rd_addr,
   output logic                                          q_pop,
   output logic                                          clearing,
   input  logic                                          pop,
   output logic                                          empty,
   output tgbu_pkg::rsp_type                             rsp_data
);

   localparam int DEPTH  = 2 * GRID_ROWS * GRID_COLS;
   localparam int AW     = $clog2(DEPTH);
   localparam int OD     = tgbu_pkg::OUT_DEPTH;
   localparam int OPW    = $clog2(OD);
   localparam int OCW    = $clog2(OD + 1);
   localparam int SW     = tgbu_pkg::SAMPLE_W;
   localparam int GW     = tgbu_pkg::GRAY_W;
   localparam int CW     = tgbu_pkg::COORD_W;
   localparam int SUMW   = tgbu_pkg::SUM_W;
   localparam int PW     = tgbu_pkg::WPROD_W;
   localparam int WSTAGE = 1 + tgbu_pkg::DIV_STAGES;
   localparam int LAST   = WSTAGE + 4;

   localparam logic [1:0] WEIGHT_DIV  = 2'd0;
   localparam logic [1:0] WEIGHT_ZERO = 2'd1;
   localparam logic [1:0] WEIGHT_FULL = 2'd2;

   typedef struct packed {
      logic [3:0][SW-1:0] corner;
      logic [CW-1:0]      screen_y;
      logic [CW-1:0]      screen_x;
      logic               in_range;
      logic [1:0]         mode_y;
      logic [1:0]         mode_x;
   } carry_type;

   function automatic logic [GW-1:0] pick_weight(input logic [1:0] mode,
                                                  input logic [GW-1:0] q);
      case (mode)
         WEIGHT_DIV:  return q;
         WEIGHT_FULL: return '1;
         default:     return '0;
      endcase
   endfunction

   // clear sweep after reset
   logic          clear_ff, clear_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   assign clearing = clear_ff;

   // issue
   logic [OCW-1:0] used_ff, used_in;
   logic [OCW-1:0] out_count_ff, out_count_in;
   logic           issue, out_pop, out_push;

   assign q_pop = q_valid && !clear_ff && (!q_cmd.is_query || (used_ff < OCW'(OD)));
   assign issue = q_pop && q_cmd.is_query;

   // grid stores, one copy per corner
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [SW-1:0] ram_wdata;
   logic [SW-1:0] corner_q [4];

   assign ram_we    = clear_ff || (q_pop && !q_cmd.is_query && q_cmd.write_ok);
   assign ram_waddr = clear_ff ? clr_addr_ff : q_wr_addr;
   assign ram_wdata = clear_ff ? '0 : q_cmd.sample;

   for (genvar i = 0; i < 4; i++) begin : g_copy
      tgbu_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ram (
         .clock (clock),
         .we    (ram_we),
         .waddr (ram_waddr),
         .wdata (ram_wdata),
         .raddr (q_rd_addr[i]),
         .rdata (corner_q[i])
      );
   end

   // stage 1: weight setup, coordinates
   logic [LAST:1]             s_valid_ff;
   tgbu_pkg::cmd_type         s1_cmd_ff;
   carry_type                 carry_in;
   carry_type                 carry_ff [2:LAST];
   logic [tgbu_pkg::NUM_W-1:0] numer_y, numer_x;
   logic [GW-1:0]             quot_y, quot_x;

   always_comb begin
      logic [tgbu_pkg::DISP_W-1:0] sy, sx;
      sy = {1'b0, s1_cmd_ff.sub_y};
      sx = {1'b0, s1_cmd_ff.sub_x};
      numer_y = {s1_cmd_ff.sub_y, 8'b0} - tgbu_pkg::NUM_W'(s1_cmd_ff.sub_y);
      numer_x = {s1_cmd_ff.sub_x, 8'b0} - tgbu_pkg::NUM_W'(s1_cmd_ff.sub_x);
      for (int i = 0; i < 4; i++) begin
         carry_in.corner[i] = corner_q[i];
      end
      carry_in.screen_y = CW'(32'(s1_cmd_ff.cell_row) * 32'(block_h)
                              + 32'(s1_cmd_ff.sub_y) + 32'(s1_cmd_ff.base_y));
      carry_in.screen_x = CW'(32'(s1_cmd_ff.cell_col) * 32'(block_w)
                              + 32'(s1_cmd_ff.sub_x) + 32'(s1_cmd_ff.base_x));
      carry_in.in_range = s1_cmd_ff.in_grid && (sy < block_h) && (sx < block_w);
      carry_in.mode_y   = (block_h == '0) ? WEIGHT_ZERO :
                          (sy >= block_h) ? WEIGHT_FULL : WEIGHT_DIV;
      carry_in.mode_x   = (block_w == '0) ? WEIGHT_ZERO :
                          (sx >= block_w) ? WEIGHT_FULL : WEIGHT_DIV;
   end

   tgbu_wdiv u_div_y (.clock(clock), .numer(numer_y), .divisor(block_h), .quot(quot_y));
   tgbu_wdiv u_div_x (.clock(clock), .numer(numer_x), .divisor(block_w), .quot(quot_x));

   // weight products
   logic [3:0][PW-1:0]           wprod_in, wprod_ff;
   logic signed [SUMW-1:0]       term_in [4];
   logic signed [SUMW-1:0]       term_ff [4];
   logic signed [SUMW-1:0]       pair_ff [2];
   logic signed [SUMW-1:0]       sum_ff;
   tgbu_pkg::rsp_type            rsp_in;

   always_comb begin
      logic [GW-1:0] wy, wx, iy, ix;
      wy = pick_weight(carry_ff[WSTAGE].mode_y, quot_y);
      wx = pick_weight(carry_ff[WSTAGE].mode_x, quot_x);
      iy = ~wy;
      ix = ~wx;
      wprod_in[0] = iy * ix;
      wprod_in[1] = iy * wx;
      wprod_in[2] = wy * ix;
      wprod_in[3] = wy * wx;
   end

   always_comb begin
      logic [SW-1:0] c;
      for (int i = 0; i < 4; i++) begin
         c = carry_ff[WSTAGE+1].corner[i];
         term_in[i] = $signed({{(SUMW-SW){c[SW-1]}}, c})
                      * $signed({{(SUMW-PW){1'b0}}, wprod_ff[i]});
      end
   end

   // truncation toward zero never lifts a negative sum above zero
   always_comb begin
      rsp_in.screen_y = carry_ff[LAST].screen_y;
      rsp_in.screen_x = carry_ff[LAST].screen_x;
      rsp_in.in_range = carry_ff[LAST].in_range;
      if (sum_ff[SUMW-1]) begin
         rsp_in.gray_value = '0;
      end else if (|sum_ff[SUMW-2:16+GW]) begin
         rsp_in.gray_value = '1;
      end else begin
         rsp_in.gray_value = sum_ff[16+GW-1:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= '0;
      end else begin
         s_valid_ff <= {s_valid_ff[LAST-1:1], issue};
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= q_cmd;
      carry_ff[2] <= carry_in;
      for (int k = 3; k <= LAST; k++) begin
         carry_ff[k] <= carry_ff[k-1];
      end
      wprod_ff   <= wprod_in;
      term_ff    <= term_in;
      pair_ff[0] <= term_ff[0] + term_ff[1];
      pair_ff[1] <= term_ff[2] + term_ff[3];
      sum_ff     <= pair_ff[0] + pair_ff[1];
   end

   // result queue with credits reserved at issue
   tgbu_pkg::rsp_type out_mem [OD];
   logic [OPW-1:0]    out_wptr_ff, out_rptr_ff;

   assign out_push = s_valid_ff[LAST];
   assign out_pop  = pop && !empty;
   assign empty    = (out_count_ff == '0);
   assign rsp_data = out_mem[out_rptr_ff];

   always_comb begin
      used_in      = used_ff;
      out_count_in = out_count_ff;
      if (issue && !out_pop) begin
         used_in = used_ff + 1'b1;
      end else if (!issue && out_pop) begin
         used_in = used_ff - 1'b1;
      end
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (!out_push && out_pop) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         used_ff      <= '0;
         out_count_ff <= '0;
         out_wptr_ff  <= '0;
         out_rptr_ff  <= '0;
      end else begin
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         used_ff      <= used_in;
         out_count_ff <= out_count_in;
         if (out_push) begin
            out_wptr_ff <= (out_wptr_ff == OPW'(OD - 1)) ? '0 : out_wptr_ff + 1'b1;
         end
         if (out_pop) begin
            out_rptr_ff <= (out_rptr_ff == OPW'(OD - 1)) ? '0 : out_rptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem[out_wptr_ff] <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_credit_cover: assert property (@(posedge clock) disable iff (reset)
      out_count_ff <= used_ff)
      else $error("result queue holds more than reserved credits");

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !q_pop)
      else $error("command taken during clear sweep");

   a_issue_lands: assert property (@(posedge clock) disable iff (reset)
      issue |-> ##LAST s_valid_ff[LAST])
      else $error("issued query did not reach result queue");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (out_push && !out_pop) |=> (out_count_ff == $past(out_count_ff) + 1'b1))
      else $error("result count did not follow push");
`endif

endmodule

// ===== rtl/thermal_grid_bilinear_upscaler.sv =====
// Throughput: one request per cycle while not full; queries and writes issue one per cycle
//   while a result credit is free. Path: command queue, grid read, dividers, adder tree.
// Result queue of 16 with credits taken at issue keeps the pipeline from ever stalling.
// Reset: synchronous; afterwards both grids are swept to zero, one word per cycle,
//   all 2*GRID_ROWS*GRID_COLS words (128 by default), with full held high meanwhile.
// Display registers reset to 240 x 320.
module thermal_grid_bilinear_upscaler #(
   parameter int GRID_ROWS = tgbu_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = tgbu_pkg::GRID_COLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  tgbu_pkg::req_type                   req_data,
   output logic                                full,
   output logic                                empty,
   input  logic                                pop,
   output tgbu_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [tgbu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tgbu_pkg::DISP_W-1:0]         csr_data
);

   localparam int AW      = $clog2(2 * GRID_ROWS * GRID_COLS);
   localparam int DW      = tgbu_pkg::DISP_W;
   localparam int RECIP_W = tgbu_pkg::RECIP_SHIFT + 1;
   localparam int PROD_W  = DW + RECIP_W;
   // block size = display / (grid - 1) via reciprocal; exact for 11-bit displays
   localparam logic [RECIP_W-1:0] RECIP_H =
      RECIP_W'(((1 << tgbu_pkg::RECIP_SHIFT) + GRID_ROWS - 2) / (GRID_ROWS - 1));
   localparam logic [RECIP_W-1:0] RECIP_W_C =
      RECIP_W'(((1 << tgbu_pkg::RECIP_SHIFT) + GRID_COLS - 2) / (GRID_COLS - 1));

   // display size registers
   logic [DW-1:0] disp_h_ff, disp_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_h_ff <= tgbu_pkg::DISPLAY_HEIGHT_RST;
         disp_w_ff <= tgbu_pkg::DISPLAY_WIDTH_RST;
      end else if (csr_write) begin
         case (csr_index)
            tgbu_pkg::CSR_DISPLAY_HEIGHT: disp_h_ff <= csr_data;
            tgbu_pkg::CSR_DISPLAY_WIDTH:  disp_w_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // block sizes, refreshed every cycle from the display registers
   logic [PROD_W-1:0] prod_h, prod_w;
   logic [DW-1:0]     block_h_ff, block_w_ff;

   assign prod_h = PROD_W'(disp_h_ff) * PROD_W'(RECIP_H);
   assign prod_w = PROD_W'(disp_w_ff) * PROD_W'(RECIP_W_C);

   always_ff @(posedge clock) begin
      block_h_ff <= prod_h[tgbu_pkg::RECIP_SHIFT +: DW];
      block_w_ff <= prod_w[tgbu_pkg::RECIP_SHIFT +: DW];
   end

   // front: request intake and command queue
   logic                   q_valid, q_pop, clearing;
   tgbu_pkg::cmd_type      q_cmd;
   logic [AW-1:0]          q_wr_addr;
   logic [3:0][AW-1:0]     q_rd_addr;

   tgbu_front #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .busy      (clearing),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_cmd     (q_cmd),
      .q_wr_addr (q_wr_addr),
      .q_rd_addr (q_rd_addr)
   );

   // back: grid writes, interpolation, results
   tgbu_back #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .block_h   (block_h_ff),
      .block_w   (block_w_ff),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_wr_addr (q_wr_addr),
      .q_rd_addr (q_rd_addr),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/testbench.sv =====
// Testbench for the thermal grid bilinear upscaler: directed and random requests with a scoreboard.
`timescale 1ns / 100ps

module testbench;

   localparam int ROWS      = tgbu_pkg::GRID_ROWS_DEF;
   localparam int COLS      = tgbu_pkg::GRID_COLS_DEF;
   localparam int CELLS     = ROWS * COLS;
   localparam int DRAIN     = 24;     // pad generously beyond the pipeline depth
   localparam int HANG_MAX  = 4000;   // cycles with no request or result accepted
   localparam int MAX_SHOWN = 10;

   // Scoreboard: keeps its own copy of both grids and the display size, and
   // predicts the pixel each query produces.
   class pixel_board;
      logic signed [tgbu_pkg::SAMPLE_W-1:0] live [CELLS];
      logic signed [tgbu_pkg::SAMPLE_W-1:0] backg[CELLS];
      int unsigned          disp_h, disp_w;
      tgbu_pkg::rsp_type    pending[$];
      int                   errors;

      function void clear_all();
         for (int i = 0; i < CELLS; i++) begin
            live[i]  = '0;
            backg[i] = '0;
         end
         disp_h = tgbu_pkg::DISPLAY_HEIGHT_RST;
         disp_w = tgbu_pkg::DISPLAY_WIDTH_RST;
         errors = 0;
      endfunction

      function longint corner(logic sel, int r, int c);
         int idx;
         idx = ((r < ROWS) ? r : ROWS - 1) * COLS + ((c < COLS) ? c : COLS - 1);
         return sel ? longint'(backg[idx]) : longint'(live[idx]);
      endfunction

      function longint blend_weight(int unsigned sub, int unsigned blk);
         int unsigned w;
         if (blk == 0) return 0;
         w = sub * 255 / blk;
         return (w > 255) ? 255 : w;
      endfunction

      // Called for every accepted request.
      function void note_request(tgbu_pkg::req_type r);
         int unsigned       bh, bw, row, col;
         longint            wy, wx, acc, val;
         tgbu_pkg::rsp_type p;
         row = r.cell_row;
         col = r.cell_col;
         if (r.operation == tgbu_pkg::OP_WRITE) begin
            if (row < ROWS && col < COLS) begin
               if (r.grid_select) backg[row*COLS+col] = r.sample;
               else               live[row*COLS+col]  = r.sample;
            end
            return;
         end
         bh  = disp_h / (ROWS - 1);
         bw  = disp_w / (COLS - 1);
         wy  = blend_weight(r.sub_y, bh);
         wx  = blend_weight(r.sub_x, bw);
         acc = corner(r.grid_select, row, col)         * ((255-wy)*(255-wx))
             + corner(r.grid_select, row, col+1)       * ((255-wy)*wx)
             + corner(r.grid_select, row+1, col)       * (wy*(255-wx))
             + corner(r.grid_select, row+1, col+1)     * (wy*wx);
         val = acc / 65536;   // signed division truncates toward zero
         if (val < 0)   val = 0;
         if (val > 255) val = 255;
         p.gray_value = val[tgbu_pkg::GRAY_W-1:0];
         p.screen_y   = tgbu_pkg::COORD_W'(row*bh + r.sub_y + r.base_y);
         p.screen_x   = tgbu_pkg::COORD_W'(col*bw + r.sub_x + r.base_x);
         p.in_range   = (row + 1 < ROWS) && (col + 1 < COLS) && (r.sub_y < bh)
                        && (r.sub_x < bw);
         pending.push_back(p);
      endfunction

      // Called for every accepted result.
      function void check_pixel(tgbu_pkg::rsp_type got);
         tgbu_pkg::rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display("unexpected result: gray %0d y %0d x %0d ok %0d",
                        got.gray_value, got.screen_y, got.screen_x, got.in_range);
            return;
         end
         want = pending.pop_front();
         if (got.gray_value !== want.gray_value || got.screen_y !== want.screen_y ||
             got.screen_x !== want.screen_x || got.in_range !== want.in_range) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display({"mismatch: expected gray %0d y %0d x %0d ok %0d, ",
                         "got gray %0d y %0d x %0d ok %0d"},
                        want.gray_value, want.screen_y, want.screen_x, want.in_range,
                        got.gray_value, got.screen_y, got.screen_x, got.in_range);
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             push;
   tgbu_pkg::req_type                req_data;
   logic                             full;
   logic                             empty;
   logic                             pop;
   tgbu_pkg::rsp_type                rsp_data;
   logic                             csr_write;
   logic [tgbu_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tgbu_pkg::DISP_W-1:0]      csr_data;

   pixel_board board;
   int         send_idle_pct;   // chance of a gap before each request
   int         recv_stall_pct;  // chance of holding pop low in a cycle
   int         hang_count;

   thermal_grid_bilinear_upscaler uut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Monitor: both channels sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full)  board.note_request(req_data);
         if (pop && !empty)  board.check_pixel(rsp_data);
      end
   end

   // Watchdog: a run that stops moving ends as a failure.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         hang_count <= 0;
      end else begin
         hang_count <= hang_count + 1;
         if (hang_count >= HANG_MAX) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Result side: random stalls drawn each cycle.
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // One request; waits for acceptance and leaves push high for the next call.
   task automatic send_request(tgbu_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         push = 1'b0;
         @(negedge clock);
      end
      push     = 1'b1;
      req_data = r;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   task automatic write_sample(int sel, int r, int c, int v);
      tgbu_pkg::req_type q;
      q             = '0;
      q.operation   = tgbu_pkg::OP_WRITE;
      q.grid_select = 1'(sel);
      q.cell_row    = tgbu_pkg::CELL_W'(r);
      q.cell_col    = tgbu_pkg::CELL_W'(c);
      q.sample      = tgbu_pkg::SAMPLE_W'(v);
      q.sub_y       = tgbu_pkg::SUB_W'($urandom);   // ignored on writes, toggled anyway
      q.base_x      = tgbu_pkg::SUB_W'($urandom);
      send_request(q);
   endtask

   task automatic query_pixel(int sel, int r, int c, int sy, int sx, int by, int bx);
      tgbu_pkg::req_type q;
      q.operation   = tgbu_pkg::OP_QUERY;
      q.grid_select = 1'(sel);
      q.cell_row    = tgbu_pkg::CELL_W'(r);
      q.cell_col    = tgbu_pkg::CELL_W'(c);
      q.sample      = tgbu_pkg::SAMPLE_W'($urandom);  // ignored on queries
      q.sub_y       = tgbu_pkg::SUB_W'(sy);
      q.sub_x       = tgbu_pkg::SUB_W'(sx);
      q.base_y      = tgbu_pkg::SUB_W'(by);
      q.base_x      = tgbu_pkg::SUB_W'(bx);
      send_request(q);
   endtask

   // Display registers change only with the pipeline empty and quiet.
   task automatic wait_idle();
      push = 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   task automatic set_display(int h, int w);
      wait_idle();
      csr_write = 1'b1;
      csr_index = tgbu_pkg::CSR_DISPLAY_HEIGHT;
      csr_data  = tgbu_pkg::DISP_W'(h);
      @(negedge clock);
      csr_index = tgbu_pkg::CSR_DISPLAY_WIDTH;
      csr_data  = tgbu_pkg::DISP_W'(w);
      @(negedge clock);
      csr_write = 1'b0;
      board.disp_h = h;
      board.disp_w = w;
   endtask

   // Random mix: mostly queries inside the block, some past it, plenty of writes.
   task automatic random_phase(int count);
      int bh, bw, sy, sx, v;
      bh = board.disp_h / (ROWS - 1);
      bw = board.disp_w / (COLS - 1);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 35) begin
            // small samples give mid-range gray, full range exercises the clamp
            v = ($urandom_range(1)) ? $urandom_range(400) - 60 : $urandom;
            write_sample($urandom, $urandom, $urandom, v);
         end else begin
            if ($urandom_range(99) < 80 && bh > 0) sy = $urandom_range(bh - 1);
            else                                   sy = $urandom;
            if ($urandom_range(99) < 80 && bw > 0) sx = $urandom_range(bw - 1);
            else                                   sx = $urandom;
            query_pixel($urandom, $urandom_range(99) < 85 ? $urandom_range(ROWS - 2)
                                                          : $urandom_range(7),
                        $urandom_range(99) < 85 ? $urandom_range(COLS - 2)
                                                : $urandom_range(7),
                        sy, sx, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      board          = new();
      board.clear_all();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      push           = 1'b0;
      req_data       = '0;
      csr_write      = 1'b0;
      csr_index      = tgbu_pkg::CSR_DISPLAY_HEIGHT;
      csr_data       = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed: reset display size, zero grid, corner and clamp cases.
      query_pixel(0, 0, 0, 0, 0, 0, 0);                  // cleared grid reads zero
      write_sample(0, 0, 0, 2047);
      write_sample(0, 0, 1, -2048);
      write_sample(0, 1, 0, 200);
      write_sample(0, 1, 1, 100);
      write_sample(1, 7, 7, 150);
      write_sample(1, 6, 6, -1);
      query_pixel(0, 0, 0, 0, 0, 0, 0);                  // bright corner clamps to 255
      query_pixel(0, 0, 0, 33, 0, 0, 0);                 // last row inside the block
      query_pixel(0, 0, 0, 17, 22, 5, 9);
      query_pixel(0, 0, 0, 0, 45, 0, 0);                 // toward the negative corner
      query_pixel(0, 0, 0, 1023, 1023, 0, 0);            // sub offset past the block
      query_pixel(1, 7, 7, 0, 0, 0, 0);                  // corner beyond the grid
      query_pixel(1, 6, 6, 20, 20, 0, 0);
      query_pixel(1, 7, 0, 10, 10, 1023, 1023);          // largest base offsets
      query_pixel(1, 0, 7, 1023, 1023, 1023, 1023);

      // Each phase picks a display size and an idling pattern.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_display(1024, 1024);
            1: set_display(1, 1);          // both block sizes zero
            2: set_display(7, 7);          // smallest nonzero block
            3: set_display(6, 1024);
            4: set_display(1024, 13);
            5: set_display(240, 320);
            6: set_display(100, 700);
            default: set_display($urandom_range(1, 1024), $urandom_range(1, 1024));
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         random_phase(215);
      end

      wait_idle();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tgbu_pkg.sv
rtl/tgbu_ram.sv
rtl/tgbu_front.sv
rtl/tgbu_wdiv.sv
rtl/tgbu_back.sv
rtl/thermal_grid_bilinear_upscaler.sv
bench/testbench.sv
